/* sv/rbd_pkg.sv */
// rbd_pkg: shared types and codes for the ring buffer deque.
// Used by rbd_cell and ring_buffer_deque; depends on nothing.
package rbd_pkg;

    // Operation codes on the func input
    typedef enum logic [2:0] {
        FUNC_PUSH_FRONT = 3'd0,
        FUNC_PUSH_BACK  = 3'd1,
        FUNC_POP_FRONT  = 3'd2,
        FUNC_POP_BACK   = 3'd3,
        FUNC_READ       = 3'd4
    } t_func;

    // Result status codes
    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_RANGE = 2'd3
    } t_status;

    // Per-cycle command broadcast to every cell
    typedef struct packed {
        logic shr;      // shift toward the back (push front)
        logic shl;      // shift toward the front (pop front)
        logic ld_back;  // load push word into the cell at the count
    } t_cell_ctl;

    localparam int unsigned FUNC_BITS  = 3;
    localparam int unsigned POS_BITS   = 4;
    localparam int unsigned CAP_BITS   = 5;
    localparam int unsigned IO_BITS    = 32;
    localparam logic [CAP_BITS-1:0] CAP_RESET = 5'd16;

endpackage

/* sv/rbd_cell.sv */
// rbd_cell: one storage cell of the deque chain, holding the entry at a fixed
// offset from the front. Depends on rbd_pkg.
module rbd_cell #(
    parameter int unsigned IDX   = 0,
    parameter int unsigned WB    = 32,
    parameter int unsigned CW    = 5,
    parameter int unsigned SW    = 5
) (
    input  logic               i_clk,
    input  rbd_pkg::t_cell_ctl i_ctl,
    input  logic [CW-1:0]      i_cnt,
    input  logic [SW-1:0]      i_sel,
    input  logic [WB-1:0]      i_left,
    input  logic [WB-1:0]      i_right,
    input  logic [WB-1:0]      i_push,
    output logic [WB-1:0]      o_data,
    output logic [WB-1:0]      o_hit_data
);

    logic [WB-1:0] r_data;
    logic          w_at_cnt;
    logic          w_hit;

    assign w_at_cnt = (i_cnt == CW'(IDX));
    assign w_hit    = (i_sel == SW'(IDX));

    // Entry update: shift from a neighbor or load at the back end
    always_ff @(posedge i_clk) begin
        priority if (i_ctl.shr) begin
            r_data <= i_left;
        end else if (i_ctl.shl) begin
            r_data <= i_right;
        end else if (i_ctl.ld_back && w_at_cnt) begin
            r_data <= i_push;
        end else begin
            r_data <= r_data;   // hold
        end
    end

    assign o_data     = r_data;
    // Drive the shared read bus only when selected
    assign o_hit_data = w_hit ? r_data : '0;

endmodule

/* sv/ring_buffer_deque.sv */
// ring_buffer_deque: double-ended queue built as a shifting chain of cells.
// Depends on rbd_pkg and rbd_cell.
//
//  Channel   Signals                                  Direction  Handshake
//  command   start, busy, i_func, i_push_value,       in         start & !busy
//            i_position
//  result    o_valid, o_status, o_value_out,          out        o_valid, one cycle
//            o_occupancy, o_is_empty, o_is_full
//  config    i_cfg_valid, o_cfg_ready, i_cfg_data     in         valid & ready
//
// One request per cycle: busy stays low, and the result of a request shows
// on the result ports with o_valid in the following cycle. Each request passes
// through the cell chain (shift, load or select) and then one result register.
// Reset (synchronous, active low) empties the deque and sets capacity to 16.
// Results are not held: the receiver takes each one in its strobe cycle.
module ring_buffer_deque #(
    parameter int unsigned DEPTH     = 16,
    parameter int unsigned WORD_BITS = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [rbd_pkg::FUNC_BITS-1:0]     i_func,
    input  logic signed [rbd_pkg::IO_BITS-1:0] i_push_value,
    input  logic [rbd_pkg::POS_BITS-1:0]      i_position,
    output logic                              o_valid,
    output logic [1:0]                        o_status,
    output logic signed [rbd_pkg::IO_BITS-1:0] o_value_out,
    output logic [rbd_pkg::CAP_BITS-1:0]      o_occupancy,
    output logic                              o_is_empty,
    output logic                              o_is_full,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [rbd_pkg::CAP_BITS-1:0]      i_cfg_data
);

    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam int unsigned SW = (CW > rbd_pkg::POS_BITS) ? CW : rbd_pkg::POS_BITS;
    localparam int unsigned WB = WORD_BITS;

    // Control and result registers
    logic [rbd_pkg::CAP_BITS-1:0] r_cap;
    logic [CW-1:0]                r_count;
    logic                         r_valid;
    rbd_pkg::t_status             r_status;
    logic [rbd_pkg::IO_BITS-1:0]  r_value;
    logic [CW-1:0]                r_occ;
    logic                         r_empty;
    logic                         r_full;

    logic [CW-1:0]                n_count;
    rbd_pkg::t_status             n_status;
    logic                         n_use_bus;

    logic                         w_accept;
    logic [CW-1:0]                w_ecap;
    logic                         w_is_full;
    logic                         w_is_empty;
    logic [SW-1:0]                w_sel;
    logic [SW-1:0]                w_pos;
    rbd_pkg::t_cell_ctl           w_ctl;
    logic [WB-1:0]                w_push_word;
    logic [WB-1:0]                w_rd_word;
    logic [rbd_pkg::IO_BITS-1:0]  w_rd_out;

    logic [WB-1:0]                w_cell_q   [DEPTH];
    logic [WB-1:0]                w_cell_hit [DEPTH];
    logic [WB-1:0]                w_bus      [DEPTH+1];

    assign w_accept    = start & ~busy;
    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;

    // Effective capacity: zero acts as one, clamp to the chain length
    always_comb begin
        if (r_cap == '0) begin
            w_ecap = CW'(1);
        end else if (32'(r_cap) >= DEPTH) begin
            w_ecap = CW'(DEPTH);
        end else begin
            w_ecap = CW'(r_cap);
        end
    end

    assign w_is_full  = (r_count >= w_ecap);
    assign w_is_empty = (r_count == '0);
    assign w_pos      = SW'(i_position);

    // Word width conversion at the push side and the read side
    generate
        if (WB >= rbd_pkg::IO_BITS) begin : g_wide
            assign w_push_word = WB'(i_push_value);
            assign w_rd_out    = w_rd_word[rbd_pkg::IO_BITS-1:0];
        end else begin : g_narrow
            assign w_push_word = i_push_value[WB-1:0];
            assign w_rd_out    = {{(rbd_pkg::IO_BITS-WB){w_rd_word[WB-1]}}, w_rd_word};
        end
    endgenerate

    // Decode the request into a cell command, new count and status
    always_comb begin
        w_ctl     = '0;
        w_sel     = '0;
        n_count   = r_count;
        n_status  = rbd_pkg::ST_DONE;
        n_use_bus = 1'b0;
        unique case (rbd_pkg::t_func'(i_func))
            rbd_pkg::FUNC_PUSH_FRONT: begin
                if (w_is_full) begin
                    n_status = rbd_pkg::ST_FULL;
                end else begin
                    w_ctl.shr = w_accept;
                    n_count   = r_count + CW'(1);
                end
            end
            rbd_pkg::FUNC_PUSH_BACK: begin
                if (w_is_full) begin
                    n_status = rbd_pkg::ST_FULL;
                end else begin
                    w_ctl.ld_back = w_accept;
                    n_count       = r_count + CW'(1);
                end
            end
            rbd_pkg::FUNC_POP_FRONT: begin
                if (w_is_empty) begin
                    n_status = rbd_pkg::ST_EMPTY;
                end else begin
                    w_ctl.shl = w_accept;
                    n_use_bus = 1'b1;
                    n_count   = r_count - CW'(1);
                end
            end
            rbd_pkg::FUNC_POP_BACK: begin
                if (w_is_empty) begin
                    n_status = rbd_pkg::ST_EMPTY;
                end else begin
                    w_sel     = SW'(r_count - CW'(1));
                    n_use_bus = 1'b1;
                    n_count   = r_count - CW'(1);
                end
            end
            rbd_pkg::FUNC_READ: begin
                if (w_is_empty) begin
                    n_status = rbd_pkg::ST_EMPTY;
                end else if (w_pos >= SW'(r_count)) begin
                    n_status = rbd_pkg::ST_RANGE;
                end else begin
                    w_sel     = w_pos;
                    n_use_bus = 1'b1;
                end
            end
            default: begin
                // unused codes leave everything as is
            end
        endcase
    end

    // Cell chain: cell 0 is the front, neighbors feed each other
    assign w_bus[0] = '0;
    generate
        for (genvar g = 0; g < DEPTH; g++) begin : g_cell
            logic [WB-1:0] w_left;
            logic [WB-1:0] w_right;
            if (g == 0) begin : g_first
                assign w_left = w_push_word;
            end else begin : g_mid_l
                assign w_left = w_cell_q[g-1];
            end
            if (g == DEPTH - 1) begin : g_last
                assign w_right = '0;
            end else begin : g_mid_r
                assign w_right = w_cell_q[g+1];
            end

            rbd_cell #(
                .IDX (g),
                .WB  (WB),
                .CW  (CW),
                .SW  (SW)
            ) u_cell (
                .i_clk      (i_clk),
                .i_ctl      (w_ctl),
                .i_cnt      (r_count),
                .i_sel      (w_sel),
                .i_left     (w_left),
                .i_right    (w_right),
                .i_push     (w_push_word),
                .o_data     (w_cell_q[g]),
                .o_hit_data (w_cell_hit[g])
            );

            // Read bus: only the selected cell drives nonzero data
            assign w_bus[g+1] = w_bus[g] | w_cell_hit[g];
        end
    endgenerate

    assign w_rd_word = w_bus[DEPTH];

    // Control state: capacity, count, result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap   <= rbd_pkg::CAP_RESET;
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= w_accept;
            if (i_cfg_valid && o_cfg_ready) begin
                r_cap   <= i_cfg_data;
                r_count <= '0;
            end else if (w_accept) begin
                r_count <= n_count;
            end
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status <= n_status;
            r_value  <= n_use_bus ? w_rd_out : '0;
            r_occ    <= n_count;
            r_empty  <= (n_count == '0);
            r_full   <= (n_count == w_ecap);
        end
    end

    assign o_valid     = r_valid;
    assign o_status    = r_status;
    assign o_value_out = r_value;
    assign o_occupancy = rbd_pkg::CAP_BITS'(r_occ);
    assign o_is_empty  = r_empty;
    assign o_is_full   = r_full;

endmodule
